>>> src/ippc_pkg.sv
package ippc_pkg;

    // Region size; the byte offset wraps to zero at this length.
    localparam int REGION_BYTES = 131072;
    localparam int OFS_W        = $clog2(REGION_BYTES);

    // Fixed field widths
    localparam int PREFIX_W   = 40;
    localparam int BYTE_W     = 8;
    localparam int CFG_OFS_W  = 17;
    localparam int CNT_W      = 17;
    localparam int TOTAL_W    = 18;
    localparam int CRC_W      = 32;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int WIN_BYTES  = 5;
    localparam int FILL_W     = 3;

    // Offset compare width: both operands fit with a spare sign bit.
    localparam int CMP_W = ((OFS_W > CFG_OFS_W) ? OFS_W : CFG_OFS_W) + 1;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [OFS_W-1:0]  OFS_LAST  = OFS_W'(REGION_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_BYTES);

    // Register reset values
    localparam logic [PREFIX_W-1:0]  RST_PREFIX  = 40'h00_40AD_1000;
    localparam logic [BYTE_W-1:0]    RST_REPLACE = 8'h10;
    localparam logic [CFG_OFS_W-1:0] RST_END     = 17'd114731;
    localparam logic [CFG_OFS_W-1:0] RST_STORE   = 17'd114732;
    localparam logic                 RST_LITTLE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX  = 3'd0,
        CFG_REPLACE = 3'd1,
        CFG_END     = 3'd2,
        CFG_STORE   = 3'd3,
        CFG_LITTLE  = 3'd4
    } t_cfg_idx;

    // Register set as seen by the datapath
    typedef struct packed {
        logic [PREFIX_W-1:0]  prefix;
        logic [BYTE_W-1:0]    replace;
        logic [CFG_OFS_W-1:0] end_ofs;
        logic [CFG_OFS_W-1:0] store_ofs;
        logic                 little;
    } t_cfg;

    // One classified byte handed from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0] patched;
        logic              changed;
        logic [CNT_W-1:0]  count;
        logic [OFS_W-1:0]  offset;
        logic              last;
    } t_work;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reflected CRC-32, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/ippc_if.sv
interface ippc_in_if;
    logic                           valid;
    logic                           ready;
    logic [ippc_pkg::BYTE_W-1:0]    data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ippc_out_if;
    logic                           valid;
    logic                           ready;
    logic [ippc_pkg::BYTE_W-1:0]    out_byte;
    logic                           was_replaced;
    logic [ippc_pkg::TOTAL_W-1:0]   replaced_total;
    logic [ippc_pkg::CRC_W-1:0]     crc_result;
    logic                           crc_ready;
    logic                           last_out;

    modport source (output valid, output out_byte, output was_replaced,
                    output replaced_total, output crc_result, output crc_ready,
                    output last_out, input ready);
    modport sink   (input valid, input out_byte, input was_replaced,
                    input replaced_total, input crc_result, input crc_ready,
                    input last_out, output ready);
endinterface

>>> src/ippc_front.sv
module ippc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ippc_pkg::t_cfg                 i_cfg,
    input  logic                           i_take,
    input  logic [ippc_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_last_byte,
    output ippc_pkg::t_work                o_work
);

    logic [ippc_pkg::OFS_W-1:0]    r_offset, n_offset;
    logic [ippc_pkg::PREFIX_W-1:0] r_window, n_window;
    logic [ippc_pkg::FILL_W-1:0]   r_fill, n_fill;
    logic [ippc_pkg::CNT_W-1:0]    r_count, n_count;

    logic                          match;
    logic                          changed;
    logic [ippc_pkg::BYTE_W-1:0]   patched;
    logic [ippc_pkg::CNT_W-1:0]    count_upd;

    always_comb begin
        match     = (r_fill == ippc_pkg::FILL_FULL) && (r_window == i_cfg.prefix);
        patched   = match ? i_cfg.replace : i_data_byte;
        changed   = match && (i_data_byte != i_cfg.replace);
        count_upd = (changed && (r_count != ippc_pkg::COUNT_MAX)) ?
                    r_count + 1'b1 : r_count;

        o_work.patched = patched;
        o_work.changed = changed;
        o_work.count   = count_upd;
        o_work.offset  = r_offset;
        o_work.last    = i_last_byte;
    end

    always_comb begin
        n_offset = r_offset;
        n_window = r_window;
        n_fill   = r_fill;
        n_count  = r_count;
        if (i_take) begin
            if (i_last_byte) begin
                n_offset = '0;
                n_window = '0;
                n_fill   = '0;
                n_count  = '0;
            end else begin
                n_offset = (r_offset == ippc_pkg::OFS_LAST) ? '0 : r_offset + 1'b1;
                n_window = {r_window[ippc_pkg::PREFIX_W-ippc_pkg::BYTE_W-1:0], patched};
                n_fill   = (r_fill == ippc_pkg::FILL_FULL) ? r_fill : r_fill + 1'b1;
                n_count  = count_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_window <= '0;
            r_fill   <= '0;
            r_count  <= '0;
        end else begin
            r_offset <= n_offset;
            r_window <= n_window;
            r_fill   <= n_fill;
            r_count  <= n_count;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ippc_pkg::FILL_FULL)
        else $error("window fill out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_byte) |=> (r_offset == '0 && r_fill == '0 && r_count == '0))
        else $error("front state not cleared after last byte");

endmodule

>>> src/ippc_fifo.sv
module ippc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ippc_pkg::t_work i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output ippc_pkg::t_work o_data,
    input  logic            i_pop
);

    ippc_pkg::t_work                r_mem [ippc_pkg::QUEUE_DEPTH];
    logic [ippc_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [ippc_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [ippc_pkg::QCNT_W-1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == ippc_pkg::QCNT_W'(ippc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == ippc_pkg::QPTR_W'(ippc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == ippc_pkg::QPTR_W'(ippc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

>>> src/ippc_back.sv
module ippc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ippc_pkg::t_cfg  i_cfg,
    input  logic            i_work_valid,
    input  ippc_pkg::t_work i_work,
    output logic            o_pop,
    ippc_out_if.source      o_rsp
);

    logic [ippc_pkg::CRC_W-1:0]   r_crc_run, n_crc_run;
    logic [ippc_pkg::CRC_W-1:0]   r_crc_fin, n_crc_fin;
    logic                         r_crc_done, n_crc_done;

    logic                         r_out_valid;
    logic [ippc_pkg::BYTE_W-1:0]  r_out_byte;
    logic                         r_out_repl;
    logic [ippc_pkg::TOTAL_W-1:0] r_out_total;
    logic [ippc_pkg::CRC_W-1:0]   r_out_crc;
    logic                         r_out_crc_rdy;
    logic                         r_out_last;

    logic [ippc_pkg::CMP_W-1:0]   ofs_ext;
    logic [ippc_pkg::CMP_W-1:0]   store_diff;
    logic                         stamp;
    logic [1:0]                   byte_sel;
    logic [ippc_pkg::BYTE_W-1:0]  emit;
    logic                         in_range;
    logic [ippc_pkg::CRC_W-1:0]   crc_next;

    assign o_pop = i_work_valid && (!r_out_valid || o_rsp.ready);

    // Stamping and CRC step for the item at the head of the queue
    always_comb begin
        ofs_ext    = ippc_pkg::CMP_W'(i_work.offset);
        store_diff = ofs_ext - ippc_pkg::CMP_W'(i_cfg.store_ofs);
        stamp      = r_crc_done && !store_diff[ippc_pkg::CMP_W-1] &&
                     (store_diff[ippc_pkg::CMP_W-2:2] == '0);
        byte_sel   = i_cfg.little ? store_diff[1:0] : ~store_diff[1:0];
        emit       = stamp ? r_crc_fin[byte_sel*ippc_pkg::BYTE_W +: ippc_pkg::BYTE_W]
                           : i_work.patched;
        in_range   = ofs_ext <= ippc_pkg::CMP_W'(i_cfg.end_ofs);
        crc_next   = ippc_pkg::crc_byte(r_crc_run, i_work.patched);

        n_crc_run  = r_crc_run;
        n_crc_fin  = r_crc_fin;
        n_crc_done = r_crc_done;
        if (!r_crc_done && in_range) begin
            n_crc_run = crc_next;
            if (ofs_ext == ippc_pkg::CMP_W'(i_cfg.end_ofs)) begin
                n_crc_fin  = crc_next ^ ippc_pkg::CRC_ONES;
                n_crc_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_run   <= ippc_pkg::CRC_ONES;
            r_crc_fin   <= '0;
            r_crc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_work.last) begin
                    r_crc_run  <= ippc_pkg::CRC_ONES;
                    r_crc_fin  <= '0;
                    r_crc_done <= 1'b0;
                end else begin
                    r_crc_run  <= n_crc_run;
                    r_crc_fin  <= n_crc_fin;
                    r_crc_done <= n_crc_done;
                end
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_byte    <= emit;
            r_out_repl    <= i_work.changed;
            r_out_total   <= ippc_pkg::TOTAL_W'(i_work.count);
            r_out_crc     <= n_crc_done ? n_crc_fin : '0;
            r_out_crc_rdy <= n_crc_done;
            r_out_last    <= i_work.last;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.out_byte       = r_out_byte;
    assign o_rsp.was_replaced   = r_out_repl;
    assign o_rsp.replaced_total = r_out_total;
    assign o_rsp.crc_result     = r_out_crc;
    assign o_rsp.crc_ready      = r_out_crc_rdy;
    assign o_rsp.last_out       = r_out_last;

    a_crc_zero_until_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_crc_rdy) |-> (r_out_crc == '0))
        else $error("CRC result shown before it is ready");

    a_crc_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_work.last) |=> (!r_crc_done && r_crc_run == ippc_pkg::CRC_ONES))
        else $error("CRC state not cleared after last byte");

endmodule

>>> src/image_pattern_patch_crc32.sv
// Streaming firmware patcher: takes one region byte per request in address
// order and returns one result per byte. Once the five previous patched bytes
// (before stamping) equal the configured prefix, the current byte is replaced
// and, if it actually changed, counted (saturating). Patched bytes up to the
// CRC end offset feed a reflected CRC-32 (poly EDB88320, preset and final XOR
// all ones); the four bytes at the store offset are then replaced by that CRC
// in the selected byte order. A request with last_byte set ends the region and
// returns all running state to its reset value. Throughput is one byte per
// clock unless the receiver stalls: the front stage classifies a byte in the
// cycle it is accepted, a two-entry queue holds it, and the back stage
// applies stamping and the CRC step and loads the output register.
// Configuration registers are to be written by the user with the block idle;
// the block does not enforce this. Writes take effect on the next request.
module image_pattern_patch_crc32 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ippc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ippc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ippc_in_if.sink                           i_req,
    ippc_out_if.source                        o_rsp
);

    ippc_pkg::t_cfg  r_cfg;
    ippc_pkg::t_work front_work;
    ippc_pkg::t_work queue_work;
    logic            take;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix    <= ippc_pkg::RST_PREFIX;
            r_cfg.replace   <= ippc_pkg::RST_REPLACE;
            r_cfg.end_ofs   <= ippc_pkg::RST_END;
            r_cfg.store_ofs <= ippc_pkg::RST_STORE;
            r_cfg.little    <= ippc_pkg::RST_LITTLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ippc_pkg::CFG_PREFIX:  r_cfg.prefix    <= i_cfg_data;
                ippc_pkg::CFG_REPLACE: r_cfg.replace   <= i_cfg_data[ippc_pkg::BYTE_W-1:0];
                ippc_pkg::CFG_END:     r_cfg.end_ofs   <= i_cfg_data[ippc_pkg::CFG_OFS_W-1:0];
                ippc_pkg::CFG_STORE:   r_cfg.store_ofs <= i_cfg_data[ippc_pkg::CFG_OFS_W-1:0];
                ippc_pkg::CFG_LITTLE:  r_cfg.little    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accept whenever the queue has room; the back drains it independently.
    assign i_req.ready = !queue_full;
    assign take        = i_req.valid && !queue_full;

    ippc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_take      (take),
        .i_data_byte (i_req.data_byte),
        .i_last_byte (i_req.last_byte),
        .o_work      (front_work)
    );

    ippc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_push_data (front_work),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_data      (queue_work),
        .i_pop       (queue_pop)
    );

    ippc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (queue_valid),
        .i_work       (queue_work),
        .o_pop        (queue_pop),
        .o_rsp        (o_rsp)
    );

endmodule

>>> tb/sv/image_pattern_patch_crc32_tb.sv
`timescale 1ns / 1ps

module image_pattern_patch_crc32_tb;

    // Run bounds.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_BYTES  = 75;
    localparam int PHASES       = 6;

    // One request: a region byte and its end-of-region mark
    typedef struct packed {
        logic [ippc_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_region_byte;

    // One result as the block should return it
    typedef struct packed {
        logic [ippc_pkg::BYTE_W-1:0]  out_byte;
        logic                         was_replaced;
        logic [ippc_pkg::TOTAL_W-1:0] total;
        logic [ippc_pkg::CRC_W-1:0]   crc;
        logic                         crc_ready;
        logic                         last;
    } t_patch_rsp;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we   = 1'b0;
    ippc_pkg::t_cfg_idx              cfg_idx  = ippc_pkg::CFG_PREFIX;
    logic [ippc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                        req_valid = 1'b0;
    logic [ippc_pkg::BYTE_W-1:0] req_byte  = '0;
    logic                        req_last  = 1'b0;
    logic                        rsp_ready = 1'b0;

    int send_idle_pct  = 16;
    int recv_stall_pct = 83;
    int mismatches     = 0;
    int cycles         = 0;

    t_region_byte region_bytes_q[$];   // requests not yet presented
    t_patch_rsp   patched_q[$];        // results owed by the block, oldest first

    // Mirror of the block: register set and per-region state
    ippc_pkg::t_cfg                cfg_m;
    logic [ippc_pkg::OFS_W-1:0]    ofs_m;
    logic [ippc_pkg::PREFIX_W-1:0] window_m;
    logic [ippc_pkg::FILL_W-1:0]   fill_m;
    logic [ippc_pkg::CRC_W-1:0]    crc_run_m;
    logic [ippc_pkg::CRC_W-1:0]    crc_fin_m;
    logic [ippc_pkg::CNT_W-1:0]    count_m;
    logic                          crc_done_m;

    ippc_in_if  req_if ();
    ippc_out_if rsp_if ();

    assign req_if.valid     = req_valid;
    assign req_if.data_byte = req_byte;
    assign req_if.last_byte = req_last;
    assign rsp_if.ready     = rsp_ready;

    image_pattern_patch_crc32 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reflected CRC-32, one data bit per iteration, LSB first
    function automatic logic [ippc_pkg::CRC_W-1:0] crc_step(
            input logic [ippc_pkg::CRC_W-1:0] crc,
            input logic [ippc_pkg::BYTE_W-1:0] b);
        logic [ippc_pkg::CRC_W-1:0] c;
        c = crc;
        for (int i = 0; i < ippc_pkg::BYTE_W; i++) begin
            c = (c >> 1) ^ (ippc_pkg::CRC_POLY & {ippc_pkg::CRC_W{c[0] ^ b[i]}});
        end
        return c;
    endfunction

    function automatic void clear_region();
        ofs_m      = '0;
        window_m   = '0;
        fill_m     = '0;
        crc_run_m  = ippc_pkg::CRC_ONES;
        crc_fin_m  = '0;
        count_m    = '0;
        crc_done_m = 1'b0;
    endfunction

    // Patch one byte, advance the CRC and the window, and return the result
    // the block owes for it.
    function automatic t_patch_rsp patch_next_byte(input logic [ippc_pkg::BYTE_W-1:0] b,
                                                   input logic last);
        t_patch_rsp                  r;
        logic [ippc_pkg::BYTE_W-1:0] patched;
        logic                        changed;
        logic                        stamp_ok;
        logic [ippc_pkg::CMP_W-1:0]  store_gap;
        logic [1:0]                  lane;
        patched  = b;
        changed  = 1'b0;
        // Stamping is judged on readiness before this byte's CRC update.
        stamp_ok = crc_done_m;

        // Match only once five earlier bytes of this region are held.
        if (fill_m >= ippc_pkg::FILL_FULL && window_m == cfg_m.prefix) begin
            patched = cfg_m.replace;
            if (b != cfg_m.replace) begin
                changed = 1'b1;
                if (count_m != ippc_pkg::COUNT_MAX) count_m = count_m + 1'b1;
            end
        end

        // The window keeps the patched byte, never the stamped one.
        window_m = {window_m[ippc_pkg::PREFIX_W-ippc_pkg::BYTE_W-1:0], patched};
        if (fill_m < ippc_pkg::FILL_FULL) fill_m = fill_m + 1'b1;

        r.out_byte = patched;
        store_gap = ippc_pkg::CMP_W'(ofs_m) - ippc_pkg::CMP_W'(cfg_m.store_ofs);
        if (stamp_ok && ofs_m >= cfg_m.store_ofs && store_gap < 4) begin
            lane = cfg_m.little ? store_gap[1:0] : 2'd3 - store_gap[1:0];
            r.out_byte = crc_fin_m[8*lane +: 8];
        end

        if (!crc_done_m && ofs_m <= cfg_m.end_ofs) begin
            crc_run_m = crc_step(crc_run_m, patched);
            if (ofs_m == cfg_m.end_ofs) begin
                crc_fin_m  = crc_run_m ^ ippc_pkg::CRC_ONES;
                crc_done_m = 1'b1;
            end
        end

        r.was_replaced = changed;
        r.total        = ippc_pkg::TOTAL_W'(count_m);
        r.crc          = crc_done_m ? crc_fin_m : '0;
        r.crc_ready    = crc_done_m;
        r.last         = last;

        ofs_m = (ofs_m == ippc_pkg::OFS_LAST) ? '0 : ofs_m + 1'b1;
        if (last) clear_region();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [ippc_pkg::CRC_W-1:0] want,
                               input logic [ippc_pkg::CRC_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Write the whole register set, one register per clock, with the block idle.
    task automatic load_config(input ippc_pkg::t_cfg c);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= ippc_pkg::CFG_PREFIX;
        cfg_data <= c.prefix;
        @(posedge i_clk);
        cfg_idx  <= ippc_pkg::CFG_REPLACE;
        cfg_data <= ippc_pkg::CFG_DATA_W'(c.replace);
        @(posedge i_clk);
        cfg_idx  <= ippc_pkg::CFG_END;
        cfg_data <= ippc_pkg::CFG_DATA_W'(c.end_ofs);
        @(posedge i_clk);
        cfg_idx  <= ippc_pkg::CFG_STORE;
        cfg_data <= ippc_pkg::CFG_DATA_W'(c.store_ofs);
        @(posedge i_clk);
        cfg_idx  <= ippc_pkg::CFG_LITTLE;
        cfg_data <= ippc_pkg::CFG_DATA_W'(c.little);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cfg_m = c;
    endtask

    // Hold until every request is taken and every result is back, then let
    // the pipeline settle.
    task automatic wait_drain();
        do @(posedge i_clk);
        while (region_bytes_q.size() != 0 || req_valid || patched_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Queue a short directed region, bytes listed first-to-last from the top
    // of the vector; the final byte closes the region.
    task automatic queue_directed(input logic [255:0] bytes, input int count);
        for (int i = 0; i < count; i++)
            region_bytes_q.insert(region_bytes_q.size(),
                                  {bytes[8*(count-1-i) +: 8], i == count - 1});
    endtask

    // Request driver: predict on acceptance, then present the next byte or
    // idle. Valid never drops while a request waits for ready.
    always @(posedge i_clk) begin : drive_requests
        t_region_byte nxt;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_if.ready)
                patched_q.insert(patched_q.size(), patch_next_byte(req_byte, req_last));
            if (!req_valid || req_if.ready) begin
                if (region_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = region_bytes_q.pop_front();
                    req_valid <= 1'b1;
                    req_byte  <= nxt.data;
                    req_last  <= nxt.last;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest owed one
    // and stall at random.
    always @(posedge i_clk) begin : check_results
        t_patch_rsp want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                if (patched_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual out_byte %0h",
                             $time, rsp_if.out_byte);
                end else begin
                    want = patched_q.pop_front();
                    check_field("out_byte", ippc_pkg::CRC_W'(want.out_byte),
                                ippc_pkg::CRC_W'(rsp_if.out_byte));
                    check_field("was_replaced", ippc_pkg::CRC_W'(want.was_replaced),
                                ippc_pkg::CRC_W'(rsp_if.was_replaced));
                    check_field("replaced_total", ippc_pkg::CRC_W'(want.total),
                                ippc_pkg::CRC_W'(rsp_if.replaced_total));
                    check_field("crc_result", want.crc, rsp_if.crc_result);
                    check_field("crc_ready", ippc_pkg::CRC_W'(want.crc_ready),
                                ippc_pkg::CRC_W'(rsp_if.crc_ready));
                    check_field("last_out", ippc_pkg::CRC_W'(want.last),
                                ippc_pkg::CRC_W'(rsp_if.last_out));
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_region_byte                phase_q[$];
        ippc_pkg::t_cfg              c;
        int                          half;
        int                          len;
        int                          start;
        int                          pick;
        int                          cut;
        int                          k;
        logic [ippc_pkg::BYTE_W-1:0] follow;

        cfg_m = {ippc_pkg::RST_PREFIX, ippc_pkg::RST_REPLACE, ippc_pkg::RST_END,
                 ippc_pkg::RST_STORE, ippc_pkg::RST_LITTLE};
        clear_region();

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset register values: the default prefix replaces the sixth byte.
        queue_directed({8'h00, 8'h40, 8'hAD, 8'h10, 8'h00, 8'h37}, 6);
        wait_drain();

        // CRC over offset zero only, stamped little-endian over the last four prefix
        // bytes; the window still sees the prefix, so the next byte is
        // replaced. A second prefix is followed by a byte already equal to
        // the replacement: emitted, not counted.
        load_config({40'hFF_0080_7F01, 8'hFF, 17'd0, 17'd1, 1'b1});
        queue_directed({8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'h00,
                        8'h00, 8'h80, 8'h7F, 8'h01, 8'hFF}, 11);
        wait_drain();

        // Zero prefix against a zero window: no match until five bytes are
        // held. End offset at its top, never reached.
        load_config({40'h00_0000_0000, 8'hAA, 17'd131071, 17'd131068, 1'b0});
        queue_directed({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 6);
        wait_drain();

        // Store offset not beyond end offset: bytes pass unstamped.
        load_config({40'hFF_FFFF_FFFF, 8'h00, 17'd2, 17'd1, 1'b0});
        queue_directed({8'h5A, 8'hA5, 8'h3C}, 3);
        wait_drain();

        // Random regions in three idle patterns: sender light and receiver
        // heavy, then swapped, then neither.
        for (int seg = 0; seg < 3; seg++) begin
            send_idle_pct  = (seg == 0) ? 16 : (seg == 1) ? 83 : 0;
            recv_stall_pct = (seg == 0) ? 83 : (seg == 1) ? 16 : 0;
            for (int ph = 0; ph < PHASES; ph++) begin
                c.replace = 8'($urandom);
                case ($urandom_range(9))
                    0: c.prefix = {5{c.replace}};
                    1: c.prefix = '0;
                    2: c.prefix = '1;
                    default: c.prefix = ippc_pkg::PREFIX_W'({$urandom, $urandom});
                endcase
                c.end_ofs = ($urandom_range(9) == 0) ?
                            ippc_pkg::CFG_OFS_W'($urandom_range(131071)) :
                            ippc_pkg::CFG_OFS_W'($urandom_range(40));
                if ($urandom_range(5) == 0)
                    c.store_ofs = ippc_pkg::CFG_OFS_W'($urandom_range(c.end_ofs));
                else if (c.end_ofs > 131056)
                    c.store_ofs = 17'd131068;
                else
                    c.store_ofs = c.end_ofs + ippc_pkg::CFG_OFS_W'($urandom_range(1, 12));
                c.little = 1'($urandom_range(1));
                load_config(c);

                // Mostly noise, plus well-formed prefixes with random follow-up bytes,
                // broken prefixes and replacement bytes.
                phase_q.delete();
                while (phase_q.size() < PHASE_BYTES) begin
                    len   = ($urandom_range(9) == 0) ? $urandom_range(60, 160)
                                                     : $urandom_range(1, 48);
                    start = phase_q.size();
                    while (phase_q.size() - start < len) begin
                        pick = $urandom_range(99);
                        if (pick < 14) begin
                            for (k = 4; k >= 0; k--)
                                phase_q.insert(phase_q.size(),
                                               {cfg_m.prefix[8*k +: 8], 1'b0});
                            follow = $urandom_range(1) ? cfg_m.replace : 8'($urandom);
                            phase_q.insert(phase_q.size(), {follow, 1'b0});
                        end else if (pick < 22) begin
                            cut = $urandom_range(1, 4);
                            for (k = 4; k > 4 - cut; k--)
                                phase_q.insert(phase_q.size(),
                                               {cfg_m.prefix[8*k +: 8], 1'b0});
                        end else if (pick < 28) begin
                            phase_q.insert(phase_q.size(), {cfg_m.replace, 1'b0});
                        end else begin
                            phase_q.insert(phase_q.size(), {8'($urandom), 1'b0});
                        end
                    end
                    phase_q[phase_q.size()-1].last = 1'b1;
                end

                // Pause the sender part way through, often mid-region, until
                // every owed result is back.
                half = $urandom_range(1, phase_q.size() - 1);
                for (k = 0; k < phase_q.size(); k++) begin
                    if (k == half) wait_drain();
                    region_bytes_q.insert(region_bytes_q.size(), phase_q[k]);
                end
                wait_drain();
            end
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
